// ===== sv/hash_bucket_slot_table_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the hash bucket slot table core.
// The assertions are sampled on clk and are held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef HASH_BUCKET_SLOT_TABLE_CORE_DEFINES_SVH
`define HASH_BUCKET_SLOT_TABLE_CORE_DEFINES_SVH

// The consequent is checked in the same cycle as the antecedent.
// It may begin with a constant ## delay.
`define HBST_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("hash bucket slot table assertion failed");

// The consequent is checked in the cycle after the antecedent.
`define HBST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hash bucket slot table assertion failed");

`endif

// ===== sv/hbst_pkg.sv =====
// ---------------------------------------------------------------------------
// hbst_pkg
// Shared widths, operation and status codes, controller states and the
// command word passed from the controller to the datapath.
// ---------------------------------------------------------------------------
package hbst_pkg;

  localparam int SLOT_COUNT_DEF = 8;
  localparam int KEY_W          = 64;
  localparam int VAL_W          = 64;
  localparam int FUNC_W         = 2;
  localparam int STATUS_W       = 2;
  localparam int SLOT_OUT_W     = 3;

  // Operation codes. Code 3 is unused and gives a not-found result.
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_PRESENT = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_MATCH,
    CTL_COMMIT
  } ctl_state_t;

  typedef struct packed {
    logic load;    // capture the request word
    logic eval;    // compare keys and pick the first hit and first free slot
    logic commit;  // update the slots and load the result word
  } dp_cmd_t;

endpackage

// ===== sv/hash_bucket_slot_table_core.sv =====
// Flow: a word accepted while busy is low passes the capture, match and
// commit steps of the controller; the result word and out_valid are registered
// at the commit, and out_valid marks the result on the out_ ports for one cycle.
// Words go one at a time; busy drops again in the cycle that shows the result.
// Reset: synchronous on rst_n low; every slot is marked empty and the controller
// returns to idle. The receiver cannot stall; each result is taken as shown.
// ---------------------------------------------------------------------------
// hash_bucket_slot_table_core
// One hash bucket of key/value slots with search, remove and insert requests.
// ---------------------------------------------------------------------------
`include "hash_bucket_slot_table_core_defines.svh"

module hash_bucket_slot_table_core #(
  parameter int SLOT_COUNT = hbst_pkg::SLOT_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [hbst_pkg::FUNC_W-1:0]     in_func,
  input  logic [hbst_pkg::KEY_W-1:0]      in_lookup_key,
  input  logic [hbst_pkg::VAL_W-1:0]      in_new_value,
  output logic                            out_valid,
  output logic [hbst_pkg::STATUS_W-1:0]   out_status,
  output logic [hbst_pkg::VAL_W-1:0]      out_found_value,
  output logic [hbst_pkg::SLOT_OUT_W-1:0] out_slot_used
);

  hbst_pkg::dp_cmd_t cmd;

  hbst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  hbst_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_func         (in_func),
    .in_lookup_key   (in_lookup_key),
    .in_new_value    (in_new_value),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_slot_used   (out_slot_used)
  );

  `HBST_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy)
  `HBST_ASSERT_SAME(a_result_three_after, start && !busy, ##3 out_valid)
  `HBST_ASSERT_NEXT(a_strobe_one_cycle, out_valid, !out_valid)
  `HBST_ASSERT_SAME(a_fail_fields_zero, out_valid && (out_status != hbst_pkg::STATUS_OK), (out_found_value == '0) && (out_slot_used == '0))

endmodule

// ===== sv/hbst_ctrl.sv =====
// ---------------------------------------------------------------------------
// hbst_ctrl
// Sequencer for one request at a time: capture, match, commit, then a
// one-cycle result strobe.
// ---------------------------------------------------------------------------
module hbst_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output hbst_pkg::dp_cmd_t cmd,
  output logic             out_valid
);

  hbst_pkg::ctl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hbst_pkg::CTL_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    busy          = 1'b1;
    case (state_r)
      hbst_pkg::CTL_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = hbst_pkg::CTL_MATCH;
        end
      end
      hbst_pkg::CTL_MATCH: begin
        cmd.eval  = 1'b1;
        state_nxt = hbst_pkg::CTL_COMMIT;
      end
      hbst_pkg::CTL_COMMIT: begin
        cmd.commit    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = hbst_pkg::CTL_IDLE;
      end
      default: begin
        state_nxt = hbst_pkg::CTL_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/hbst_datapath.sv =====
// ---------------------------------------------------------------------------
// hbst_datapath
// Slot storage, parallel key compare, first-hit and first-free selection,
// and the result word registers.
// ---------------------------------------------------------------------------
module hbst_datapath #(
  parameter int SLOT_COUNT = hbst_pkg::SLOT_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  hbst_pkg::dp_cmd_t                 cmd,
  input  logic [hbst_pkg::FUNC_W-1:0]       in_func,
  input  logic [hbst_pkg::KEY_W-1:0]        in_lookup_key,
  input  logic [hbst_pkg::VAL_W-1:0]        in_new_value,
  output logic [hbst_pkg::STATUS_W-1:0]     out_status,
  output logic [hbst_pkg::VAL_W-1:0]        out_found_value,
  output logic [hbst_pkg::SLOT_OUT_W-1:0]   out_slot_used
);

  localparam int IDX_W = $clog2(SLOT_COUNT);

  // Request word
  logic [hbst_pkg::FUNC_W-1:0] func_r;
  logic [hbst_pkg::KEY_W-1:0]  key_r;
  logic [hbst_pkg::VAL_W-1:0]  val_r;

  // Slot storage
  logic [hbst_pkg::KEY_W-1:0]  slot_keys_r   [SLOT_COUNT];
  logic [hbst_pkg::VAL_W-1:0]  slot_values_r [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]       slot_valid_r, slot_valid_nxt;

  // Match stage
  logic [SLOT_COUNT-1:0] hit_vec, hit_oh, free_vec, free_oh;
  logic [SLOT_COUNT-1:0] hit_oh_r, free_oh_r;
  logic                  hit_any_r, free_any_r;

  // Commit stage
  logic [IDX_W-1:0] hit_idx, free_idx;
  logic             write_en;

  // Result word
  logic [hbst_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic [hbst_pkg::VAL_W-1:0]      value_r, value_nxt;
  logic [hbst_pkg::SLOT_OUT_W-1:0] slot_r, slot_nxt;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      key_r  <= in_lookup_key;
      val_r  <= in_new_value;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_vec[i] = slot_valid_r[i] && (slot_keys_r[i] == key_r);
    end
    free_vec = ~slot_valid_r;
    // Keep only the lowest set bit of each vector.
    hit_oh   = hit_vec & (~hit_vec + SLOT_COUNT'(1));
    free_oh  = free_vec & (~free_vec + SLOT_COUNT'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      hit_oh_r   <= hit_oh;
      free_oh_r  <= free_oh;
      hit_any_r  <= |hit_vec;
      free_any_r <= |free_vec;
    end
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (hit_oh_r[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (free_oh_r[i]) begin
        free_idx = free_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    status_nxt     = hbst_pkg::STATUS_MISSING;
    value_nxt      = '0;
    slot_nxt       = '0;
    slot_valid_nxt = slot_valid_r;
    write_en       = 1'b0;
    case (func_r)
      hbst_pkg::FUNC_SEARCH, hbst_pkg::FUNC_REMOVE: begin
        if (hit_any_r) begin
          status_nxt = hbst_pkg::STATUS_OK;
          value_nxt  = slot_values_r[hit_idx];
          slot_nxt   = hbst_pkg::SLOT_OUT_W'(hit_idx);
          if (func_r == hbst_pkg::FUNC_REMOVE) begin
            slot_valid_nxt[hit_idx] = 1'b0;
          end
        end
      end
      hbst_pkg::FUNC_INSERT: begin
        if (hit_any_r) begin
          status_nxt = hbst_pkg::STATUS_PRESENT;
        end else if (!free_any_r) begin
          status_nxt = hbst_pkg::STATUS_FULL;
        end else begin
          status_nxt               = hbst_pkg::STATUS_OK;
          slot_nxt                 = hbst_pkg::SLOT_OUT_W'(free_idx);
          slot_valid_nxt[free_idx] = 1'b1;
          write_en                 = 1'b1;
        end
      end
      default: begin
        status_nxt = hbst_pkg::STATUS_MISSING;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (cmd.commit) begin
      slot_valid_r <= slot_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && write_en) begin
      slot_keys_r[free_idx]   <= key_r;
      slot_values_r[free_idx] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      slot_r   <= slot_nxt;
    end
  end

  assign out_status      = status_r;
  assign out_found_value = value_r;
  assign out_slot_used   = slot_r;

endmodule
